// ===== hw/rtl/soundex_encoder_top_assert.svh =====
// Assertion macros for the soundex encoder.
// Depends on signals named clk and rst in the including module.
`ifndef SOUNDEX_ENCODER_TOP_ASSERT_SVH
`define SOUNDEX_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SDX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("soundex encoder assertion failed");
`define SDX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("soundex encoder assertion failed");
`else
`define SDX_ASSERT(lbl, prop)
`define SDX_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/sdx_pkg.sv =====
// Shared types, constants and the letter class lookup for the soundex encoder.
// No dependencies.
`default_nettype none

package sdx_pkg;

  typedef logic [2:0] class_t;

  localparam class_t CLASS_NONE  = 3'd0;
  localparam class_t CLASS_LABIAL = 3'd1;
  localparam class_t CLASS_GUTTURAL = 3'd2;
  localparam class_t CLASS_DENTAL = 3'd3;
  localparam class_t CLASS_LATERAL = 3'd4;
  localparam class_t CLASS_NASAL = 3'd5;
  localparam class_t CLASS_RHOTIC = 3'd6;
  localparam class_t CLASS_VOWEL = 3'd7;

  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam int NUM_DIGITS = 3;

  // Input item held in the input register, as seen by the core.
  typedef struct packed {
    logic       valid;
    logic       word_end;
    logic [7:0] char_in;
  } stage_t;

  function automatic class_t class_of(input logic [7:0] ch);
    logic [7:0] up;
    class_t     cls;
    up = ch;
    if (ch >= "a" && ch <= "z") begin
      up = ch ^ CASE_BIT;
    end
    case (up) inside
      "A", "E", "I", "O", "U":                cls = CLASS_VOWEL;
      "B", "F", "P", "V":                     cls = CLASS_LABIAL;
      "C", "G", "J", "K", "Q", "S", "X", "Z": cls = CLASS_GUTTURAL;
      "D", "T":                               cls = CLASS_DENTAL;
      "L":                                    cls = CLASS_LATERAL;
      "M", "N":                               cls = CLASS_NASAL;
      "R":                                    cls = CLASS_RHOTIC;
      default:                                cls = CLASS_NONE;
    endcase
    // Bytes above 127 never match a letter, so they fall to CLASS_NONE.
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sdx_if.sv =====
// Valid/ready channel interfaces for the soundex encoder's character input
// and code output. No dependencies.
`default_nettype none

interface sdx_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       word_end;

  modport source (output valid, output char_in, output word_end, input ready);
  modport sink (input valid, input char_in, input word_end, output ready);
endinterface

interface sdx_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] lead_letter;
  logic [2:0] digit_one;
  logic [2:0] digit_two;
  logic [2:0] digit_three;

  modport source (output valid, output lead_letter, output digit_one,
                  output digit_two, output digit_three, input ready);
  modport sink (input valid, input lead_letter, input digit_one,
                input digit_two, input digit_three, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/soundex_encoder_top.sv =====
// Soundex encoder: one character item per cycle in, one four-character code
// out per word. A word's last item passes the input and then the result register.
// Throughput is one item per cycle, set by the single class lookup and compare
// between the input register and the word state, while no word end is blocked.
// Reset (synchronous, active high) empties both registers and expects a new word.
`default_nettype none
`include "soundex_encoder_top_assert.svh"

module soundex_encoder_top (
  input  wire logic  clk,
  input  wire logic  rst,
  sdx_char_if.sink   chars,
  sdx_code_if.source codes
);

  sdx_pkg::stage_t st;
  logic            advance;

  sdx_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .advance (advance),
    .st      (st)
  );

  sdx_word_core u_word_core (
    .clk     (clk),
    .rst     (rst),
    .st      (st),
    .advance (advance),
    .codes   (codes)
  );

  // A new result appears only after a word-ending item left the input register.
  `SDX_ASSERT_IMPL(a_result_from_end, $rose(codes.valid), $past(st.valid && st.word_end))
  // Digits are packed from the front; padding only follows real digits.
  `SDX_ASSERT_IMPL(a_pad_two, codes.valid && codes.digit_two != sdx_pkg::CLASS_NONE,
                   codes.digit_one != sdx_pkg::CLASS_NONE)
  `SDX_ASSERT_IMPL(a_pad_three, codes.valid && codes.digit_three != sdx_pkg::CLASS_NONE,
                   codes.digit_two != sdx_pkg::CLASS_NONE)
  // A blocked word end must stall the input side.
  `SDX_ASSERT(a_stall_input,
              !(st.valid && st.word_end && codes.valid && !codes.ready && chars.ready))

endmodule

`default_nettype wire

// ===== hw/rtl/sdx_in_stage.sv =====
// Input register of the soundex encoder: holds one character item.
// Depends on sdx_pkg and sdx_char_if.
`default_nettype none

module sdx_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  sdx_char_if.sink           chars,
  input  wire logic          advance,
  output sdx_pkg::stage_t    st
);

  sdx_pkg::stage_t held;

  assign chars.ready = !held.valid || advance;
  assign st          = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (chars.ready) begin
      held.valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      held.char_in  <= chars.char_in;
      held.word_end <= chars.word_end;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sdx_word_core.sv =====
// Word state and result register of the soundex encoder: classifies the held
// character, updates the word state and loads the code at the word's end.
// Depends on sdx_pkg and sdx_code_if.
`default_nettype none

module sdx_word_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sdx_pkg::stage_t st,
  output logic               advance,
  sdx_code_if.source         codes
);

  logic                at_word_start;
  logic [7:0]          first_char;
  sdx_pkg::class_t     prev_class;
  logic [1:0]          digit_count;
  sdx_pkg::class_t     digits_held [sdx_pkg::NUM_DIGITS];

  logic [7:0]          first_char_next;
  sdx_pkg::class_t     prev_class_next;
  logic [1:0]          digit_count_next;
  sdx_pkg::class_t     digits_next [sdx_pkg::NUM_DIGITS];
  sdx_pkg::class_t     cls;

  logic                out_valid;
  logic [7:0]          out_lead;
  sdx_pkg::class_t     out_digits [sdx_pkg::NUM_DIGITS];

  // A word-ending item may only move on when the result register is free.
  assign advance = st.valid && (!st.word_end || !out_valid || codes.ready);

  assign cls = sdx_pkg::class_of(st.char_in);

  always_comb begin
    first_char_next  = first_char;
    prev_class_next  = prev_class;
    digit_count_next = digit_count;
    digits_next      = digits_held;
    if (at_word_start) begin
      first_char_next  = st.char_in;
      prev_class_next  = cls;
      digit_count_next = 2'd0;
      for (int i = 0; i < sdx_pkg::NUM_DIGITS; i++) begin
        digits_next[i] = sdx_pkg::CLASS_NONE;
      end
    end else if (digit_count < 2'(sdx_pkg::NUM_DIGITS) && cls != prev_class) begin
      if (cls == sdx_pkg::CLASS_VOWEL) begin
        prev_class_next = sdx_pkg::CLASS_NONE;
      end else if (cls != sdx_pkg::CLASS_NONE) begin
        digits_next[digit_count] = cls;
        digit_count_next         = digit_count + 2'd1;
        prev_class_next          = cls;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_word_start <= 1'b1;
      first_char    <= 8'd0;
      prev_class    <= sdx_pkg::CLASS_NONE;
      digit_count   <= 2'd0;
      for (int i = 0; i < sdx_pkg::NUM_DIGITS; i++) begin
        digits_held[i] <= sdx_pkg::CLASS_NONE;
      end
    end else if (advance) begin
      if (st.word_end) begin
        at_word_start <= 1'b1;
        first_char    <= 8'd0;
        prev_class    <= sdx_pkg::CLASS_NONE;
        digit_count   <= 2'd0;
        for (int i = 0; i < sdx_pkg::NUM_DIGITS; i++) begin
          digits_held[i] <= sdx_pkg::CLASS_NONE;
        end
      end else begin
        at_word_start <= 1'b0;
        first_char    <= first_char_next;
        prev_class    <= prev_class_next;
        digit_count   <= digit_count_next;
        digits_held   <= digits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && st.word_end) begin
      out_valid <= 1'b1;
    end else if (codes.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && st.word_end) begin
      out_lead   <= first_char_next;
      out_digits <= digits_next;
    end
  end

  assign codes.valid       = out_valid;
  assign codes.lead_letter = out_lead;
  assign codes.digit_one   = out_digits[0];
  assign codes.digit_two   = out_digits[1];
  assign codes.digit_three = out_digits[2];

endmodule

`default_nettype wire

// ===== tb/soundex_check_pkg.sv =====
// Scoreboard for the soundex encoder testbench: predicts the code of each word
// from its accepted character items and checks the code items against it.
// Depends on sdx_pkg for the class codes and the digit count.
`timescale 1ns / 1ps

package soundex_check_pkg;
  import sdx_pkg::*;

  // Class digit of each letter A..Z as ASCII digits, A in the top byte.
  // Vowels carry 7, and H, W and Y carry 0 since they are skipped.
  localparam logic [26*8-1:0] LETTER_CODES = "71237120722455712623710202";

  typedef struct packed {
    logic [7:0] lead;
    class_t     d1;
    class_t     d2;
    class_t     d3;
  } sdx_code_t;

  class code_scoreboard;
    bit          in_word;
    logic [7:0]  lead;
    class_t      last_code;
    int unsigned n_digits;
    class_t      digits[NUM_DIGITS];
    sdx_code_t   pending_codes[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      start_word();
    endfunction

    function void start_word();
      in_word   = 0;
      lead      = '0;
      last_code = CLASS_NONE;
      n_digits  = 0;
      foreach (digits[i]) digits[i] = CLASS_NONE;
    endfunction

    function class_t letter_class(logic [7:0] ch);
      logic [7:0] up;
      up = ch;
      if (ch >= "a" && ch <= "z") begin
        up = ch ^ CASE_BIT;
      end
      // Anything outside A..Z, bytes above 127 included, has no class.
      if (up < "A" || up > "Z") begin
        return CLASS_NONE;
      end
      return class_t'(LETTER_CODES[(25 - int'(up - "A")) * 8 +: 8] - "0");
    endfunction

    function void note_char(logic [7:0] ch, logic last);
      class_t    cls;
      sdx_code_t code;
      cls = letter_class(ch);
      if (!in_word) begin
        // The lead letter still seeds the previous code.
        lead      = ch;
        last_code = cls;
        in_word   = 1;
      end else if (n_digits < NUM_DIGITS && cls != last_code) begin
        if (cls == CLASS_VOWEL) begin
          last_code = CLASS_NONE;
        end else if (cls != CLASS_NONE) begin
          digits[n_digits] = cls;
          n_digits++;
          last_code = cls;
        end
      end
      if (last) begin
        code.lead = lead;
        code.d1   = digits[0];
        code.d2   = digits[1];
        code.d3   = digits[2];
        pending_codes.push_back(code);
        start_word();
      end
    endfunction

    function void check_code(sdx_code_t got);
      sdx_code_t want;
      if (pending_codes.size() == 0) begin
        $error("code item with no word pending: lead_letter 0x%02h", got.lead);
        mismatches++;
        return;
      end
      want = pending_codes.pop_front();
      if (got.lead !== want.lead) begin
        $error("lead_letter: expected 0x%02h, got 0x%02h", want.lead, got.lead);
        mismatches++;
      end
      if (got.d1 !== want.d1) begin
        $error("digit_one: expected %0d, got %0d", want.d1, got.d1);
        mismatches++;
      end
      if (got.d2 !== want.d2) begin
        $error("digit_two: expected %0d, got %0d", want.d2, got.d2);
        mismatches++;
      end
      if (got.d3 !== want.d3) begin
        $error("digit_three: expected %0d, got %0d", want.d3, got.d3);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== tb/soundex_encoder_top_test.sv =====
// Top of the soundex encoder testbench: clock, reset, word stimulus with
// random idling and stalls, and the code item monitor.
// Depends on sdx_pkg, sdx_if and soundex_check_pkg.
`timescale 1ns / 1ps

module soundex_encoder_top_test;
  import sdx_pkg::*;
  import soundex_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned ITEMS_PER_PHASE  = 500;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  logic clk;
  logic rst;

  sdx_char_if chars ();
  sdx_code_if codes ();

  soundex_encoder_top u_dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .codes (codes)
  );

  code_scoreboard board = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;
  int unsigned items_sent     = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("soundex_encoder_top_test failed");
    $finish;
  end

  // Receiver side: random stalls, plus a long hold-off when one is requested.
  initial begin
    codes.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        codes.ready = 1'b0;
      end else if (hold_left > 0) begin
        codes.ready = 1'b0;
        hold_left--;
      end else begin
        codes.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    sdx_code_t got;
    forever begin
      @(posedge clk);
      if (!rst && codes.valid && codes.ready) begin
        got.lead = codes.lead_letter;
        got.d1   = codes.digit_one;
        got.d2   = codes.digit_two;
        got.d3   = codes.digit_three;
        board.check_code(got);
      end
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      chars.valid    = 1'b0;
      chars.char_in  = 8'($urandom);
      chars.word_end = 1'($urandom);
      @(negedge clk);
    end
    chars.valid    = 1'b1;
    chars.char_in  = ch;
    chars.word_end = last;
    do @(posedge clk); while (!chars.ready);
    board.note_char(ch, last);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  // Mostly letters of either case, with stray bytes mixed in; one word in
  // ten is raw noise over the whole byte range.
  task automatic send_random_word();
    int unsigned len;
    bit          noise;
    logic [7:0]  ch;
    len   = ($urandom_range(19) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
    noise = ($urandom_range(9) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if (noise || $urandom_range(99) < 12) begin
        ch = 8'($urandom);
      end else begin
        ch = 8'("A" + $urandom_range(25));
        if ($urandom_range(1) == 1) begin
          ch = ch | CASE_BIT;
        end
      end
      send_char(ch, i == len - 1);
    end
  endtask

  initial begin
    rst            = 1'b1;
    chars.valid    = 1'b0;
    chars.char_in  = '0;
    chars.word_end = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words: one-byte words, byte extremes, every class, case
    // folding, duplicates across skipped letters, and overflow past three.
    send_text("a");
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'h80, 1'b0);
    send_char("b", 1'b1);
    send_text("Bfhvat");
    send_text("lmnrqdx");
    send_char("E", 1'b0);
    send_char("k", 1'b0);
    send_char(8'h7F, 1'b0);
    send_text("ak");

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // Stop the receiver for a while so the block backs up its input.
          hold_left = LONG_HOLD_CYCLES;
        end
        1: begin
          send_idle_pct  = 53;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 53;
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
      endcase
      items_sent = 0;
      while (items_sent < ITEMS_PER_PHASE) begin
        send_random_word();
      end
    end

    @(negedge clk);
    chars.valid    = 1'b0;
    recv_stall_pct = 0;
    while (board.pending_codes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("soundex_encoder_top_test passed");
    end else begin
      $display("soundex_encoder_top_test failed");
    end
    $finish;
  end

endmodule
